>>> rtl/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg - sorted table binary search shared types
// Field widths, command codes and the search sequencer state type.
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int unsigned INDEX_W = 8;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned KEY_IN_W = 32;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SEARCH = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_EMPTY
	} state_t;

endpackage

>>> rtl/sbs_key_ram.sv
// ----------------------------------------------------------------------------
// sbs_key_ram - key table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sbs_key_ram #(
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = 8,
	parameter int unsigned DATA_W = 32
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/sbs_search_ctrl.sv
// ----------------------------------------------------------------------------
// sbs_search_ctrl - request intake and binary search sequencer
// Writes keys into the table, walks the probe sequence one read per cycle
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module sbs_search_ctrl #(
	parameter int unsigned TABLE_DEPTH = 256,
	parameter int unsigned KEY_BITS    = 32,
	parameter int unsigned ADDR_W      = 8,
	parameter int unsigned CNT_W       = 9
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [CNT_W-1:0]                     entries,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 command,
	input  logic [sbs_pkg::INDEX_W-1:0]          entry_index,
	input  logic signed [sbs_pkg::KEY_IN_W-1:0]  key_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 found,
	output logic [sbs_pkg::POS_W-1:0]            position,
	output logic                                 ram_wr_en,
	output logic [ADDR_W-1:0]                    ram_wr_addr,
	output logic [KEY_BITS-1:0]                  ram_wr_data,
	output logic                                 ram_rd_en,
	output logic [ADDR_W-1:0]                    ram_rd_addr,
	input  logic [KEY_BITS-1:0]                  ram_rd_data
);

	localparam int unsigned IDX_CMP_W = (CNT_W > sbs_pkg::INDEX_W) ? CNT_W : sbs_pkg::INDEX_W;

	sbs_pkg::state_t state_q, state_d;

	logic signed [KEY_BITS-1:0] target_q;
	logic [CNT_W-1:0]           lo_q, hi_q, mid_q;
	logic [CNT_W-1:0]           lo_d, hi_d, mid_d;
	logic                       out_valid_q, found_q;
	logic [sbs_pkg::POS_W-1:0]  position_q;

	logic                       accept, out_free;
	logic signed [KEY_BITS-1:0] key_norm, probe;
	logic                       hit, go_up, more;
	logic [CNT_W-1:0]           lo_n, hi_n;
	logic [CNT_W:0]             mid_sum;
	logic                       res_load, res_found;
	logic [CNT_W-1:0]           first_mid;

	// sign-extend or cut the incoming key to the table width
	assign key_norm = KEY_BITS'(key_value);
	assign probe    = ram_rd_data;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != sbs_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign ram_wr_en   = accept && (command == sbs_pkg::CMD_WRITE)
	                     && (IDX_CMP_W'(entry_index) < IDX_CMP_W'(TABLE_DEPTH));
	assign ram_wr_addr = ADDR_W'(entry_index);
	assign ram_wr_data = key_norm;

	// next range after a miss on the current probe
	assign hit     = (probe == target_q);
	assign go_up   = (target_q > probe);
	assign lo_n    = go_up ? (mid_q + CNT_W'(1)) : lo_q;
	assign hi_n    = go_up ? hi_q : mid_q;
	assign more    = (lo_n < hi_n);
	assign mid_sum = ({1'b0, lo_n} + {1'b0, hi_n} - (CNT_W+1)'(1)) >> 1;
	assign first_mid = (entries - CNT_W'(1)) >> 1;

	always_comb begin
		state_d   = state_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		ram_rd_en = 1'b0;
		ram_rd_addr = ADDR_W'(mid_q);
		res_load  = 1'b0;
		res_found = 1'b0;
		unique case (state_q)
			sbs_pkg::ST_IDLE: begin
				ram_rd_addr = ADDR_W'(first_mid);
				if (accept && (command == sbs_pkg::CMD_SEARCH)) begin
					if (entries == '0) begin
						state_d = sbs_pkg::ST_EMPTY;
					end else begin
						ram_rd_en = 1'b1;
						lo_d      = '0;
						hi_d      = entries;
						mid_d     = first_mid;
						state_d   = sbs_pkg::ST_PROBE;
					end
				end
			end
			sbs_pkg::ST_PROBE: begin
				if (hit || !more) begin
					// wait here until the output register can take the result
					if (out_free) begin
						res_load  = 1'b1;
						res_found = hit;
						state_d   = sbs_pkg::ST_IDLE;
					end
				end else begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = ADDR_W'(mid_sum[CNT_W-1:0]);
					lo_d        = lo_n;
					hi_d        = hi_n;
					mid_d       = mid_sum[CNT_W-1:0];
				end
			end
			sbs_pkg::ST_EMPTY: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = sbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		if (accept) begin
			target_q <= key_norm;
		end
		if (res_load) begin
			found_q    <= res_found;
			position_q <= res_found ? sbs_pkg::POS_W'(mid_q) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;

endmodule

>>> rtl/sorted_table_binary_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit - binary search over a sorted key table
// Holds ascending signed keys in a synchronous RAM and answers key lookups.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one request per handshake:
//   command write stores key_value at entry_index (no result; indexes at or
//   above the table depth are dropped), command search looks up key_value.
//   Output channel (out_valid / out_stall) returns found and position for
//   each search; position is 0 on a miss.
//   entry_count is loaded through cfg_wr_en / cfg_wr_data; the user must load
//   it while idle (the block does not enforce it); values above the table depth act as the full table.
// Timing:
//   A write is stored as the request is taken. A search issues one RAM probe
//   per cycle, the read latency of the key RAM sets that loop: up to log2(count)+1
//   probes, 9 for 256 entries. The first probe goes out as the request is
//   taken; each returned key either ends the search (hit or empty range, the
//   result loaded once the output register is free) or issues the next probe.
//   An empty table answers without a probe.
//   One request is in flight at a time; the next is taken once the result
//   sits in the output register, which holds under out_stall.
// Reset:
//   clears the sequencer, the output valid and entry_count. Table contents
//   are undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit #(
	parameter int unsigned TABLE_DEPTH = 256,
	parameter int unsigned KEY_BITS    = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [sbs_pkg::COUNT_W-1:0]          cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 command,
	input  logic [sbs_pkg::INDEX_W-1:0]          entry_index,
	input  logic signed [sbs_pkg::KEY_IN_W-1:0]  key_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 found,
	output logic [sbs_pkg::POS_W-1:0]            position
);

	localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned CMP_W  = (CNT_W > sbs_pkg::COUNT_W) ? CNT_W : sbs_pkg::COUNT_W;

	logic [sbs_pkg::COUNT_W-1:0] entry_count_q;
	logic [CNT_W-1:0]            entries;

	logic                ram_wr_en, ram_rd_en;
	logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
	logic [KEY_BITS-1:0] ram_wr_data, ram_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr_en) begin
			entry_count_q <= cfg_wr_data;
		end
	end

	// clamp the count to the table depth
	assign entries = (CMP_W'(entry_count_q) > CMP_W'(TABLE_DEPTH))
	                 ? CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_q);

	sbs_key_ram #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (KEY_BITS)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	sbs_search_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.ADDR_W      (ADDR_W),
		.CNT_W       (CNT_W)
	) u_search_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.entries     (entries),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.entry_index (entry_index),
		.key_value   (key_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.position    (position),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

endmodule
